### hdl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper: the command that
// travels from the parser to the UTF-8 encoder, status codes and queue sizes.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Queue sizes
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Code point width (up to U+10FFFF)
    localparam int CP_W = 21;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_DATA    = 2'd0;
    localparam t_status ST_CLOSED  = 2'd1;
    localparam t_status ST_NUL     = 2'd2;
    localparam t_status ST_NO_OPEN = 2'd3;

    // What the encoder has to do with a command
    typedef enum logic [1:0] {
        KIND_BYTE,   // one byte, copied as is
        KIND_CP,     // code point, encoded as 1 to 4 UTF-8 bytes
        KIND_END     // one status item with a zero byte
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [CP_W-1:0]  cp;
        t_status          status;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       last;
    } t_out;

endpackage : jsu_pkg
`default_nettype wire

### hdl/json_string_unescape_utf8.sv
// Path: an accepted byte that yields output is written to the command queue;
//   the encoder then writes its first result item into the output FIFO.
// Throughput: one input byte per cycle while the four-entry command queue has
//   room; the encoder writes one result byte per cycle while the output FIFO
//   has room, so a \u escape holds the encoder until all its bytes are written.
// Reset: synchronous, active low; clears the parser state and both queues.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string literal unescaper: parser front end, command queue and UTF-8
// encoder back end with its own output FIFO.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic             o_last
);
    import jsu_pkg::*;

    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;
    t_out res;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    jsu_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_empty (empty),
        .i_pop   (pop),
        .o_out   (res)
    );

    assign o_out_byte = res.out_byte;
    assign o_status   = res.status;
    assign o_last     = res.last;

endmodule : json_string_unescape_utf8
`default_nettype wire

### hdl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Byte parser: tracks quotes, escapes and \uXXXX digits, joins surrogate
// pairs and issues at most one command per accepted byte.
// ----------------------------------------------------------------------------
module jsu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_full,
    output logic               o_push,
    output jsu_pkg::t_cmd      o_cmd
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef enum logic [2:0] {
        M_WAIT_OPEN,
        M_IN_STR,
        M_ESC,
        M_HEX_FIRST,
        M_EXPECT_BS,
        M_EXPECT_U,
        M_HEX_SECOND
    } t_mode;

    t_mode       r_mode,      n_mode;
    logic [15:0] r_hex_value, n_hex_value;
    logic [1:0]  r_hex_cnt,   n_hex_cnt;
    logic        r_hex_bad,   n_hex_bad;
    logic [9:0]  r_high,      n_high;

    logic        accept;
    logic        cmd_valid;
    t_cmd        cmd;
    logic        do_str;
    logic        do_esc;
    logic        do_digit;
    logic [3:0]  digit;
    logic        digit_ok;
    logic [15:0] hv_new;
    logic        bad_new;
    logic [7:0]  esc_byte;

    assign accept = i_push && !i_full;

    // Hex digit decode
    always_comb begin
        digit    = 4'd0;
        digit_ok = 1'b1;
        if (i_in_byte inside {[8'h30:8'h39]}) begin
            digit = i_in_byte[3:0];
        end else if (i_in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            digit = 4'(i_in_byte[2:0] + 3'd1) + 4'd8;
        end else begin
            digit_ok = 1'b0;
        end
    end

    assign hv_new  = {r_hex_value[11:0], digit};
    assign bad_new = r_hex_bad || !digit_ok;

    // Single-character escapes
    always_comb begin
        case (i_in_byte)
            CH_B:    esc_byte = 8'h08;
            CH_F:    esc_byte = 8'h0C;
            CH_N:    esc_byte = 8'h0A;
            CH_R:    esc_byte = 8'h0D;
            CH_T:    esc_byte = 8'h09;
            default: esc_byte = i_in_byte;
        endcase
    end

    // Parser next state and command
    always_comb begin
        n_mode      = r_mode;
        n_hex_value = r_hex_value;
        n_hex_cnt   = r_hex_cnt;
        n_hex_bad   = r_hex_bad;
        n_high      = r_high;
        cmd_valid   = 1'b0;
        cmd.kind    = KIND_BYTE;
        cmd.cp      = '0;
        cmd.status  = ST_DATA;
        do_str      = 1'b0;
        do_esc      = 1'b0;
        do_digit    = 1'b0;

        case (r_mode)
            M_IN_STR: begin
                do_str = 1'b1;
            end
            M_ESC: begin
                do_esc = 1'b1;
            end
            M_HEX_FIRST, M_HEX_SECOND: begin
                if (i_in_byte == CH_NUL) begin
                    cmd_valid  = 1'b1;
                    cmd.kind   = KIND_END;
                    cmd.status = ST_NUL;
                    n_mode     = M_WAIT_OPEN;
                end else begin
                    do_digit = 1'b1;
                end
            end
            M_EXPECT_BS: begin
                if (i_in_byte == CH_BSL) begin
                    n_mode = M_EXPECT_U;
                end else begin
                    n_mode = M_IN_STR;
                    do_str = 1'b1;
                end
            end
            M_EXPECT_U: begin
                if (i_in_byte == CH_U) begin
                    n_hex_value = '0;
                    n_hex_cnt   = '0;
                    n_hex_bad   = 1'b0;
                    n_mode      = M_HEX_SECOND;
                end else begin
                    do_esc = 1'b1;
                end
            end
            default: begin
                // waiting for the opening quote
                if (i_in_byte == CH_QUOTE) begin
                    n_mode = M_IN_STR;
                end else begin
                    cmd_valid  = 1'b1;
                    cmd.kind   = KIND_END;
                    cmd.status = ST_NO_OPEN;
                    n_mode     = M_WAIT_OPEN;
                end
            end
        endcase

        // plain string byte
        if (do_str) begin
            if (i_in_byte == CH_QUOTE) begin
                cmd_valid  = 1'b1;
                cmd.kind   = KIND_END;
                cmd.status = ST_CLOSED;
                n_mode     = M_WAIT_OPEN;
            end else if (i_in_byte == CH_NUL) begin
                cmd_valid  = 1'b1;
                cmd.kind   = KIND_END;
                cmd.status = ST_NUL;
                n_mode     = M_WAIT_OPEN;
            end else if (i_in_byte == CH_BSL) begin
                n_mode = M_ESC;
            end else begin
                cmd_valid = 1'b1;
                cmd.cp    = CP_W'(i_in_byte);
            end
        end

        // byte after a backslash
        if (do_esc) begin
            if (i_in_byte == CH_NUL) begin
                cmd_valid  = 1'b1;
                cmd.kind   = KIND_END;
                cmd.status = ST_NUL;
                n_mode     = M_WAIT_OPEN;
            end else if (i_in_byte == CH_U) begin
                n_hex_value = '0;
                n_hex_cnt   = '0;
                n_hex_bad   = 1'b0;
                n_mode      = M_HEX_FIRST;
            end else begin
                cmd_valid = 1'b1;
                cmd.cp    = CP_W'(esc_byte);
                n_mode    = M_IN_STR;
            end
        end

        // one of four hex digits
        if (do_digit) begin
            n_hex_value = hv_new;
            n_hex_cnt   = r_hex_cnt + 2'd1;
            n_hex_bad   = bad_new;
            if (r_hex_cnt == 2'd3) begin
                n_mode = M_IN_STR;
                if (r_mode == M_HEX_FIRST) begin
                    if (bad_new || hv_new == 16'h0000 ||
                        hv_new inside {[16'hDC00:16'hDFFF]}) begin
                        // nothing to emit
                    end else if (hv_new inside {[16'hD800:16'hDBFF]}) begin
                        n_high = hv_new[9:0];
                        n_mode = M_EXPECT_BS;
                    end else begin
                        cmd_valid = 1'b1;
                        cmd.kind  = KIND_CP;
                        cmd.cp    = CP_W'(hv_new);
                    end
                end else if (!bad_new && hv_new inside {[16'hDC00:16'hDFFF]}) begin
                    cmd_valid = 1'b1;
                    cmd.kind  = KIND_CP;
                    cmd.cp    = CP_W'(21'h10000) + CP_W'({r_high, hv_new[9:0]});
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_WAIT_OPEN;
            r_hex_value <= '0;
            r_hex_cnt   <= '0;
            r_hex_bad   <= 1'b0;
            r_high      <= '0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_hex_value <= n_hex_value;
            r_hex_cnt   <= n_hex_cnt;
            r_hex_bad   <= n_hex_bad;
            r_high      <= n_high;
        end
    end

    assign o_push = accept && cmd_valid;
    assign o_cmd  = cmd;

endmodule : jsu_front
`default_nettype wire

### hdl/jsu_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_cmd_queue
// Small FIFO of parser commands between the parser and the UTF-8 encoder.
// ----------------------------------------------------------------------------
module jsu_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jsu_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output jsu_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import jsu_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;
    logic                 push_ok;
    logic                 pop_ok;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + CMD_PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + CMD_PTR_W'(1);
            end
            r_count <= r_count + CMD_CNT_W'(push_ok) - CMD_CNT_W'(pop_ok);
        end
    end

endmodule : jsu_cmd_queue
`default_nettype wire

### hdl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// UTF-8 encoder: expands each command into one to four result items, one per
// cycle while there is room, into a small output FIFO that faces the consumer.
// ----------------------------------------------------------------------------
module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire jsu_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output jsu_pkg::t_out      o_out
);
    import jsu_pkg::*;

    t_out                 r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic [1:0]           r_idx;

    logic [1:0]           len_m1;
    logic [7:0]           enc_byte;
    logic                 item_last;
    logic                 do_emit;
    logic                 pop_ok;
    t_out                 item;

    // Encoded length minus one
    always_comb begin
        len_m1 = 2'd0;
        if (i_cmd.kind == KIND_CP) begin
            if (i_cmd.cp < CP_W'(21'h80)) begin
                len_m1 = 2'd0;
            end else if (i_cmd.cp < CP_W'(21'h800)) begin
                len_m1 = 2'd1;
            end else if (i_cmd.cp < CP_W'(21'h10000)) begin
                len_m1 = 2'd2;
            end else begin
                len_m1 = 2'd3;
            end
        end
    end

    // Byte at the current position
    always_comb begin
        enc_byte = 8'h00;
        case (i_cmd.kind)
            KIND_BYTE: enc_byte = i_cmd.cp[7:0];
            KIND_CP: begin
                case (len_m1)
                    2'd0: enc_byte = i_cmd.cp[7:0];
                    2'd1: enc_byte = (r_idx == 2'd0) ? {3'b110, i_cmd.cp[10:6]}
                                                      : {2'b10, i_cmd.cp[5:0]};
                    2'd2: begin
                        case (r_idx)
                            2'd0:    enc_byte = {4'b1110, i_cmd.cp[15:12]};
                            2'd1:    enc_byte = {2'b10, i_cmd.cp[11:6]};
                            default: enc_byte = {2'b10, i_cmd.cp[5:0]};
                        endcase
                    end
                    default: begin
                        case (r_idx)
                            2'd0:    enc_byte = {5'b11110, i_cmd.cp[20:18]};
                            2'd1:    enc_byte = {2'b10, i_cmd.cp[17:12]};
                            2'd2:    enc_byte = {2'b10, i_cmd.cp[11:6]};
                            default: enc_byte = {2'b10, i_cmd.cp[5:0]};
                        endcase
                    end
                endcase
            end
            default: enc_byte = 8'h00;
        endcase
    end

    assign item_last     = (r_idx == len_m1);
    assign do_emit       = i_valid && (r_count != OUT_CNT_W'(OUT_DEPTH));
    assign o_pop         = do_emit && item_last;
    assign item.out_byte = enc_byte;
    assign item.status   = (i_cmd.kind == KIND_END) ? i_cmd.status : ST_DATA;
    assign item.last     = item_last;

    assign o_empty = (r_count == '0);
    assign o_out   = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && !o_empty;

    // Output storage
    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    // Byte position, pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_emit) begin
                r_idx    <= item_last ? 2'd0 : r_idx + 2'd1;
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + OUT_CNT_W'(do_emit) - OUT_CNT_W'(pop_ok);
        end
    end

endmodule : jsu_back
`default_nettype wire

### hdl/jsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic [1:0] o_status,
    input wire logic       o_last
);
    import jsu_pkg::*;

    // Reset leaves both queues drained
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A status item carries a zero byte and closes its group
    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_DATA) |-> (o_out_byte == 8'h00 && o_last))
        else $error("status item with data byte or without last");

    // Input side only fills up through accepted items
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an accepted item");

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) &&
                              $stable(o_status) && $stable(o_last)))
        else $error("waiting result changed before it was taken");

endmodule : jsu_checker

bind json_string_unescape_utf8 jsu_checker u_checker (.*);
`default_nettype wire
